>>> rtl/core/crcv_pkg.sv
// Shared types, constants and CRC matrix builder for the CRC block validator.
package crcv_pkg;

    localparam int PAYLOAD_BYTES  = 4096;
    localparam int HEADER_BYTES   = 64;
    localparam int HEADER_WORDS   = HEADER_BYTES / 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int VALID_W        = 13;
    localparam int CFG_REGS       = 4;
    localparam int CFG_ADDR_W     = 5;

    localparam logic [63:0] MAGIC_WORD = 64'h3150_4752_3253_5256;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    // header word positions
    localparam logic [2:0] HW_MAGIC   = 3'd0;
    localparam logic [2:0] HW_SECTION = 3'd1;
    localparam logic [2:0] HW_CRCS    = 3'd2;
    localparam logic [2:0] HW_ZERO    = 3'd3;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_ID_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] crc;
        logic [63:0] data;
        logic [3:0]  nbytes;
    } t_crc_req;

    // row i: mask over {data[63:0], crc[31:0]} giving next crc bit i
    typedef logic [31:0][95:0] t_crc_mat;

    function automatic t_crc_mat crc_matrix(input int nbytes);
        t_crc_mat    m;
        logic [31:0] c;
        logic [63:0] d;
        int          i;
        int          j;
        int          k;
        int          b;
        m = '0;
        for (j = 0; j < 96; j++) begin
            c = '0;
            d = '0;
            if (j < 32) begin
                c[j] = 1'b1;
            end else begin
                d[j-32] = 1'b1;
            end
            for (k = 0; k < nbytes; k++) begin
                c = c ^ {24'b0, d[8*k +: 8]};
                for (b = 0; b < 8; b++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
            for (i = 0; i < 32; i++) begin
                m[i][j] = c[i];
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/crcv_lane.sv
// One CRC-32 lane: advances the CRC over a fixed number of leading bytes.
module crcv_lane #(
    parameter int NBYTES = 8
) (
    input  logic [31:0] i_crc,
    input  logic [63:0] i_data,
    output logic [31:0] o_crc
);
    import crcv_pkg::*;

    localparam t_crc_mat MAT = crc_matrix(NBYTES);

    logic [95:0] vec;

    assign vec = {i_data, i_crc};

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            o_crc[i] = ^(MAT[i] & vec);
        end
    end

endmodule

>>> rtl/core/crcv_crc_unit.sv
// Byte-count lanes for one word and the merge that picks the lane result.
module crcv_crc_unit (
    input  crcv_pkg::t_crc_req i_req,
    output logic [31:0]        o_crc,
    output logic               o_pad_bad
);
    import crcv_pkg::*;

    logic [31:0] lane_crc [1:BYTES_PER_WORD];

    for (genvar n = 1; n <= BYTES_PER_WORD; n++) begin : g_lane
        crcv_lane #(
            .NBYTES(n)
        ) u_lane (
            .i_crc (i_req.crc),
            .i_data(i_req.data),
            .o_crc (lane_crc[n])
        );
    end

    always_comb begin
        unique case (i_req.nbytes)
            4'd1:    o_crc = lane_crc[1];
            4'd2:    o_crc = lane_crc[2];
            4'd3:    o_crc = lane_crc[3];
            4'd4:    o_crc = lane_crc[4];
            4'd5:    o_crc = lane_crc[5];
            4'd6:    o_crc = lane_crc[6];
            4'd7:    o_crc = lane_crc[7];
            4'd8:    o_crc = lane_crc[8];
            default: o_crc = i_req.crc;
        endcase
    end

    // nonzero bytes beyond the counted ones
    always_comb begin
        o_pad_bad = 1'b0;
        for (int k = 0; k < BYTES_PER_WORD; k++) begin
            if (4'(k) >= i_req.nbytes && i_req.data[8*k +: 8] != 8'h00) begin
                o_pad_bad = 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/crc_block_validator.sv
// Top level: stored-block header and payload validator with APB id registers.
// Throughput: one 64-bit word per cycle, (64 + P_PAYLOAD_BYTES) / 8 words per block.
// Each word's CRC step finishes in its own cycle through eight parallel byte-count lanes.
// Latency: status is registered, valid the cycle after the last word is taken.
// Input stalls only on a last word while an earlier status is still held.
// Synchronous active-low reset clears block state, id registers and output.
module crc_block_validator #(
    parameter int P_PAYLOAD_BYTES = crcv_pkg::PAYLOAD_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [63:0]                     i_block_word,
    input  logic [31:0]                     i_expected_section,
    input  logic [31:0]                     i_expected_index,
    input  logic [crcv_pkg::VALID_W-1:0]    i_expected_valid,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crcv_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    import crcv_pkg::*;

    localparam int BLOCK_WORDS = (HEADER_BYTES + P_PAYLOAD_BYTES) / BYTES_PER_WORD;
    localparam int POS_W       = $clog2(BLOCK_WORDS);
    localparam int OFF_W       = $clog2(P_PAYLOAD_BYTES);
    localparam int CW          = ((OFF_W > VALID_W) ? OFF_W : VALID_W) + 1;

    logic [63:0]      r_id [CFG_REGS];
    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_hcrc;
    logic [31:0]      r_pcrc;
    logic [31:0]      r_spcrc;
    logic [31:0]      r_shcrc;
    logic             r_inv;
    logic             r_idm;
    logic             r_pad;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;

    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    logic             accept;
    logic             last;
    logic             is_hdr;
    logic [2:0]       hidx;
    logic [POS_W-1:0] pay_word;
    logic [CW-1:0]    off;
    logic [CW-1:0]    vext;
    logic [CW-1:0]    diff;
    logic [3:0]       pay_n;
    logic             valid_over;
    logic             hdr_inv;
    logic             id_bad;
    logic [CFG_REGS-1:0] id_eq;
    logic             inv_word;
    logic             pad_word;
    logic             inv_all;
    logic             pad_all;
    t_crc_req         req;
    logic [31:0]      crc_out;
    logic             pad_bad;

    // config port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = r_id[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_id[i] <= '0;
            end
        end else if (cfg_wr) begin
            r_id[cfg_idx] <= pwdata;
        end
    end

    // handshake
    assign last    = r_pos == POS_W'(BLOCK_WORDS - 1);
    assign o_stall = last && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_status = r_status;

    // word decode
    assign is_hdr   = r_pos < POS_W'(HEADER_WORDS);
    assign hidx     = r_pos[2:0];
    assign pay_word = r_pos - POS_W'(HEADER_WORDS);
    assign off      = CW'({pay_word, 3'b000});
    assign vext     = CW'(i_expected_valid);
    assign diff     = vext - off;
    assign valid_over = vext > CW'(P_PAYLOAD_BYTES);

    always_comb begin
        priority if (vext <= off) begin
            pay_n = 4'd0;
        end else if (diff >= CW'(BYTES_PER_WORD)) begin
            pay_n = 4'(BYTES_PER_WORD);
        end else begin
            pay_n = diff[3:0];
        end
    end

    always_comb begin
        for (int k = 0; k < CFG_REGS; k++) begin
            id_eq[k] = i_block_word == r_id[k];
        end
    end

    always_comb begin
        hdr_inv = 1'b0;
        id_bad  = 1'b0;
        unique case (hidx)
            HW_MAGIC:   hdr_inv = i_block_word != MAGIC_WORD;
            HW_SECTION: hdr_inv = (i_block_word[31:0] != i_expected_section) ||
                                  (i_block_word[63:32] != i_expected_index);
            HW_CRCS:    hdr_inv = i_block_word[31:0] != 32'(i_expected_valid);
            HW_ZERO:    hdr_inv = i_block_word[63:32] != 32'h0;
            default:    id_bad  = !id_eq[hidx[1:0]];
        endcase
    end

    // CRC request: header skips bytes 24-27
    always_comb begin
        if (is_hdr) begin
            req.crc = r_hcrc;
            if (hidx == HW_ZERO) begin
                req.data   = {32'h0, i_block_word[63:32]};
                req.nbytes = 4'd4;
            end else begin
                req.data   = i_block_word;
                req.nbytes = 4'(BYTES_PER_WORD);
            end
        end else begin
            req.crc    = r_pcrc;
            req.data   = i_block_word;
            req.nbytes = pay_n;
        end
    end

    crcv_crc_unit u_crc (
        .i_req    (req),
        .o_crc    (crc_out),
        .o_pad_bad(pad_bad)
    );

    assign inv_word = valid_over || (is_hdr && hdr_inv);
    assign pad_word = !is_hdr && pad_bad;
    assign inv_all  = r_inv || inv_word || ((~crc_out) != r_spcrc) || ((~r_hcrc) != r_shcrc);
    assign pad_all  = r_pad || pad_word;

    always_comb begin
        priority if (inv_all) begin
            n_status = ST_INVALID;
        end else if (r_idm) begin
            n_status = ST_ID_MISMATCH;
        end else if (pad_all) begin
            n_status = ST_INVALID;
        end else begin
            n_status = ST_OK;
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hcrc  <= CRC_PRESET;
            r_pcrc  <= CRC_PRESET;
            r_spcrc <= '0;
            r_shcrc <= '0;
            r_inv   <= 1'b0;
            r_idm   <= 1'b0;
            r_pad   <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_pos   <= '0;
                r_hcrc  <= CRC_PRESET;
                r_pcrc  <= CRC_PRESET;
                r_spcrc <= '0;
                r_shcrc <= '0;
                r_inv   <= 1'b0;
                r_idm   <= 1'b0;
                r_pad   <= 1'b0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
                if (is_hdr) begin
                    r_hcrc <= crc_out;
                end else begin
                    r_pcrc <= crc_out;
                end
                if (is_hdr && hidx == HW_CRCS) begin
                    r_spcrc <= i_block_word[63:32];
                end
                if (is_hdr && hidx == HW_ZERO) begin
                    r_shcrc <= i_block_word[31:0];
                end
                r_inv <= r_inv || inv_word;
                r_idm <= r_idm || (is_hdr && id_bad);
                r_pad <= r_pad || pad_word;
            end
        end
    end

    // status word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else if (accept && last) begin
            r_out_valid <= 1'b1;
            r_status    <= n_status;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/core/crcv_checker.sv
// Port-level checker for the CRC block validator, bound to the top level.
module crcv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status
);
    import crcv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("status word dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_INVALID ||
                     o_status == ST_ID_MISMATCH))
        else $error("illegal status code");

    a_rise_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("status word without an input word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output");

endmodule

bind crc_block_validator crcv_checker u_crcv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_status(o_status)
);
